// ----- rtl/gkp_pkg.sv -----
// Package: shared constants, register indexes and the decoded geometry type.
`timescale 1ns / 1ps
package gkp_pkg;

	// Window depth and derived widths
	localparam int MAX_WINDOW = 32;
	localparam int IDX_W      = $clog2(MAX_WINDOW);
	localparam int CNT_W      = $clog2(MAX_WINDOW + 1);

	// Field widths
	localparam int SYM_W      = 8;
	localparam int WORD_W     = 16;
	localparam int POS_W      = 9;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 8;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_BITS   = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAP_LENGTH    = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SKIP_COUNT    = 4'd3;

	// Decoded window geometry, shared by all cells
	typedef struct packed {
		logic [SYM_W-1:0] sym_mask;  // symbol bits that survive the 16-bit cut
		logic [3:0]       bits;      // bits per symbol
		logic [4:0]       gap;       // gap length
		logic [CNT_W-1:0] w_eff;     // window span clamped to MAX_WINDOW
		logic [CNT_W-1:0] head;      // newest kept symbols end here
		logic [CNT_W-1:0] tail;      // oldest kept symbols start here
	} gkp_geom_t;

endpackage

// ----- rtl/gkp_if.sv -----
// Interfaces: symbol input, packed word output and configuration write channels.
`timescale 1ns / 1ps

interface gkp_sym_if;
	import gkp_pkg::*;
	logic             valid;
	logic             ready;
	logic [SYM_W-1:0] symbol;
	logic             end_of_sequence;
	modport source (output valid, symbol, end_of_sequence, input ready);
	modport sink   (input valid, symbol, end_of_sequence, output ready);
endinterface

interface gkp_word_if;
	import gkp_pkg::*;
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] packed_word;
	logic              last;
	modport source (output valid, packed_word, last, input ready);
	modport sink   (input valid, packed_word, last, output ready);
endinterface

interface gkp_cfg_if;
	import gkp_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/gkp_cfg.sv -----
// Configuration registers and decode of the window geometry.
`timescale 1ns / 1ps
module gkp_cfg
	import gkp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	gkp_cfg_if.sink   cfg,
	output logic [7:0] skip_count,
	output gkp_geom_t geom
);

	logic [3:0] symbol_bits_q;
	logic [5:0] window_length_q;
	logic [4:0] gap_length_q;
	logic [7:0] skip_count_q;

	int w_int, keep_int, head_int, top_int, nb_int;
	logic active, top_ok;

	assign cfg.ready  = 1'b1;
	assign skip_count = skip_count_q;

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			symbol_bits_q   <= 4'd2;
			window_length_q <= 6'd3;
			gap_length_q    <= 5'd0;
			skip_count_q    <= 8'd0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_SYMBOL_BITS:   symbol_bits_q   <= cfg.data[3:0];
				CFG_WINDOW_LENGTH: window_length_q <= cfg.data[5:0];
				CFG_GAP_LENGTH:    gap_length_q    <= cfg.data[4:0];
				CFG_SKIP_COUNT:    skip_count_q    <= cfg.data[7:0];
				default: ;
			endcase
		end
	end

	// Geometry decode; the user must keep it static while items flow, the block does not enforce this
	always_comb begin
		w_int    = (int'(window_length_q) > MAX_WINDOW) ? MAX_WINDOW : int'(window_length_q);
		active   = (w_int != 0) && (int'(gap_length_q) < w_int);
		keep_int = active ? (w_int - int'(gap_length_q)) : 1;
		head_int = keep_int / 2;
		top_int  = int'(symbol_bits_q) * (keep_int - 1);
		top_ok   = top_int < WORD_W;
		nb_int   = top_ok ? (WORD_W - top_int) : 0;

		geom.bits  = symbol_bits_q;
		geom.gap   = gap_length_q;
		geom.w_eff = CNT_W'(w_int);
		geom.head  = CNT_W'(head_int);
		geom.tail  = CNT_W'(head_int + int'(gap_length_q));
		if (!active || !top_ok)
			geom.sym_mask = '0;
		else if (nb_int >= SYM_W)
			geom.sym_mask = '1;
		else
			geom.sym_mask = SYM_W'((1 << nb_int) - 1);
	end

endmodule

// ----- rtl/gkp_cell.sv -----
// One window cell: holds a symbol, passes it on, and places its slot in the word.
`timescale 1ns / 1ps
module gkp_cell
	import gkp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [IDX_W-1:0]  idx,
	input  gkp_geom_t         geom,
	input  logic              shift_en,
	input  logic              clear,
	input  logic [SYM_W-1:0]  d_in,
	output logic [SYM_W-1:0]  d_out,
	output logic [WORD_W-1:0] contrib_s1
);

	logic [SYM_W-1:0]   data_q;
	logic [CNT_W-1:0]   idx_ext;
	logic               kept;
	logic [IDX_W-1:0]   slot;
	logic [IDX_W+3:0]   prod;
	logic [3:0]         sh;
	logic [WORD_W-1:0]  ext;

	assign d_out = data_q;

	// Slot of this position among the kept symbols
	always_comb begin
		idx_ext = CNT_W'(idx);
		kept    = (idx_ext < geom.w_eff) && ((idx_ext < geom.head) || (idx_ext >= geom.tail));
		slot    = (idx_ext < geom.head) ? idx : (idx - IDX_W'(geom.gap));
		prod    = (IDX_W + 4)'(geom.bits) * (IDX_W + 4)'(slot);
		sh      = prod[3:0];
		ext     = {{(WORD_W - SYM_W){1'b0}}, d_in & geom.sym_mask};
	end

	// Window shift, cleared after the last symbol
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			data_q <= '0;
		else if (shift_en)
			data_q <= clear ? '0 : d_in;
	end

	// Slot contribution of the incoming symbol
	always_ff @(posedge clk) begin
		if (shift_en)
			contrib_s1 <= kept ? (ext << sh) : '0;
	end

endmodule

// ----- rtl/gapped_kmer_packer.sv -----
// Top level: gapped k-mer packer built from a shifting row of window cells.
//
//  channel   dir  payload                         transfer when
//  cfg       in   index[3:0], data[7:0]           cfg.valid & cfg.ready (ready tied high)
//  symbols   in   symbol[7:0], end_of_sequence    symbols.valid & symbols.ready
//  words     out  packed_word[15:0], last         words.valid & words.ready
//
//  One symbol per cycle while the output does not stall; a word is registered in the
//  cell stage, then goes through the OR tree into the output register.
//  Reset clears the window, position counter, stage valids and loads register defaults.
//  A stalled output holds the word; the cell stage still takes symbols while it holds no valid word.
//  Positions below skip_count produce no word, but still shift the window.
`timescale 1ns / 1ps
module gapped_kmer_packer
	import gkp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	gkp_cfg_if.sink     cfg,
	gkp_sym_if.sink     symbols,
	gkp_word_if.source  words
);

	gkp_geom_t          geom;
	logic [7:0]         skip_count;
	logic [SYM_W-1:0]   win   [MAX_WINDOW];
	logic [WORD_W-1:0]  contrib [MAX_WINDOW];

	logic [POS_W-1:0]   pos_q;
	logic               emit;
	logic               in_xfer;
	logic               s1_en, out_en;
	logic               s1_valid_s1, last_s1;
	logic               out_valid_q, last_q;
	logic [WORD_W-1:0]  word_q;
	logic [WORD_W-1:0]  word_or;

	gkp_cfg u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.skip_count (skip_count),
		.geom       (geom)
	);

	// Handshake and stage enables
	assign out_en          = !out_valid_q || words.ready;
	assign s1_en           = !s1_valid_s1 || out_en;
	assign symbols.ready   = s1_en;
	assign in_xfer         = symbols.valid && s1_en;
	assign emit            = pos_q >= POS_W'(skip_count);

	// Row of window cells
	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		gkp_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.idx        (IDX_W'(i)),
			.geom       (geom),
			.shift_en   (in_xfer),
			.clear      (symbols.end_of_sequence),
			.d_in       ((i == 0) ? symbols.symbol : win[(i == 0) ? 0 : i - 1]),
			.d_out      (win[i]),
			.contrib_s1 (contrib[i])
		);
	end

	// Position counter, saturating, cleared after the last symbol
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pos_q <= '0;
		else if (in_xfer) begin
			if (symbols.end_of_sequence)
				pos_q <= '0;
			else if (pos_q != '1)
				pos_q <= pos_q + 1'b1;
		end
	end

	// Cell stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			s1_valid_s1 <= 1'b0;
		else if (s1_en)
			s1_valid_s1 <= in_xfer && emit;
	end

	always_ff @(posedge clk) begin
		if (in_xfer)
			last_s1 <= symbols.end_of_sequence;
	end

	// OR tree over the cell contributions
	always_comb begin
		word_or = '0;
		for (int j = 0; j < MAX_WINDOW; j++)
			word_or = word_or | contrib[j];
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_en)
			out_valid_q <= s1_valid_s1;
	end

	always_ff @(posedge clk) begin
		if (out_en && s1_valid_s1) begin
			word_q <= word_or;
			last_q <= last_s1;
		end
	end

	assign words.valid       = out_valid_q;
	assign words.packed_word = word_q;
	assign words.last        = last_q;

	// Checks
	a_eos_clears_pos: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && symbols.end_of_sequence |=> pos_q == '0)
		else $error("position counter not cleared after last symbol");

	a_eos_clears_win: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && symbols.end_of_sequence |=> win[0] == '0)
		else $error("window not cleared after last symbol");

	a_emit_follows_skip: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> s1_valid_s1 == $past(emit))
		else $error("cell stage valid does not match skip decision");

	a_pos_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && !symbols.end_of_sequence && pos_q == '1 |=> pos_q == '1)
		else $error("position counter wrapped");

endmodule
